@@ rtl/bst_pkg.sv @@
// Shared types for the breakpoint slot table: request and result words,
// request codes and the controller/datapath command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int ADDR_BITS_DEF = 32;

  typedef enum logic [2:0] {
    MODE_SET      = 3'd0,
    MODE_REM_SLOT = 3'd1,
    MODE_REM_ADDR = 3'd2,
    MODE_ENABLE   = 3'd3,
    MODE_DISABLE  = 3'd4,
    MODE_FIND     = 3'd5,
    MODE_HIT      = 3'd6,
    MODE_READ     = 3'd7
  } bst_mode_t;

  typedef struct packed {
    bst_mode_t   mode;
    logic [31:0] address;
    logic [3:0]  slot_id;
    logic [1:0]  bp_type;
    logic [31:0] bp_length;
  } bst_in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  slot_out;
    logic [31:0] entry_address;
    logic [1:0]  entry_type;
    logic [31:0] entry_length;
    logic        entry_enabled;
    logic [31:0] entry_hits;
  } bst_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;      // latch the incoming word, reset the scan
    logic scan_run;      // issue the next scan read
    logic rd_slot;       // read the slot named by slot_id
    logic rd_match;      // read the hits of the slot just matched
    logic retire_direct; // finish a remove-slot, enable or disable
    logic retire_scan;   // finish set, remove-address or find at the match
    logic retire_fetch;  // finish read or hit from the fetched word
    logic retire_fail;   // finish with ok low
  } bst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    bst_mode_t mode;
    logic      sid_ok;
    logic      match;
    logic      scan_end;
  } bst_sts_t;

endpackage

@@ rtl/bst_ctrl.sv @@
// Request sequencer for the breakpoint slot table.
// Depends on bst_pkg; drives bst_dp through bst_cmd_t.
`timescale 1ns / 1ps

module bst_ctrl
  import bst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bst_sts_t sts,
  output bst_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DISPATCH = 4'b0010,
    ST_SCAN     = 4'b0100,
    ST_FETCH    = 4'b1000
  } bst_state_t;

  bst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts.mode)
          MODE_SET, MODE_REM_ADDR, MODE_FIND, MODE_HIT: begin
            cmd.scan_run = 1'b1;
            state_nxt    = ST_SCAN;
          end
          MODE_REM_SLOT, MODE_ENABLE, MODE_DISABLE: begin
            cmd.retire_direct = 1'b1;
            state_nxt         = ST_IDLE;
          end
          default: begin
            if (sts.sid_ok) begin
              cmd.rd_slot = 1'b1;
              state_nxt   = ST_FETCH;
            end else begin
              cmd.retire_fail = 1'b1;
              state_nxt       = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.match) begin
          if (sts.mode == MODE_HIT) begin
            cmd.rd_match = 1'b1;
            state_nxt    = ST_FETCH;
          end else begin
            cmd.retire_scan = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (sts.scan_end) begin
          cmd.retire_fail = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.retire_fetch = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bst_dp.sv @@
// Datapath of the breakpoint slot table: slot memories, enable flags,
// the one-slot-per-cycle scan and the result register.
// Depends on bst_pkg; commanded by bst_ctrl.
`timescale 1ns / 1ps

module bst_dp
  import bst_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bst_in_t  in_word,
  input  bst_cmd_t cmd,
  output bst_sts_t sts,
  output logic     out_valid,
  output bst_out_t out_word
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] len;
  } bst_attr_t;

  // slot storage; an entry reads as its reset value until first written
  logic [AW-1:0] addr_mem [SLOTS];
  bst_attr_t     attr_mem [SLOTS];
  logic [31:0]   hits_mem [SLOTS];

  logic [SLOTS-1:0] en_r, en_nxt;
  logic [SLOTS-1:0] av_r, av_nxt;   // addr/attr entry written
  logic [SLOTS-1:0] hv_r, hv_nxt;   // hits entry written

  bst_in_t       req_r;
  logic [CW-1:0] cnt_r;
  logic          chk_vld_r;
  logic [SW-1:0] chk_idx_r;
  logic [SW-1:0] fnd_idx_r;

  logic [AW-1:0] addr_q;
  bst_attr_t     attr_q;
  logic [31:0]   hits_q;

  bst_out_t res_r, res_nxt;
  logic     out_valid_r;

  logic [SW-1:0] rd_idx;
  logic [SW-1:0] sid_idx;
  logic [SW+3:0] sid_wide;
  logic [SW+2:0] chk_wide, fnd_wide;
  logic [AW-1:0] req_addr, chk_addr;
  logic          sid_ok, match, scan_more;

  logic          addr_we, attr_we, hits_we;
  logic [SW-1:0] addr_wi, attr_wi, hits_wi;
  logic [AW-1:0] addr_wd;
  bst_attr_t     attr_wd;
  logic [31:0]   hits_wd, hits_cur;

  assign sid_wide = {{SW{1'b0}}, req_r.slot_id};
  assign sid_idx  = sid_wide[SW-1:0];
  assign chk_wide = {3'b000, chk_idx_r};
  assign fnd_wide = {3'b000, fnd_idx_r};
  assign sid_ok   = (int'(req_r.slot_id) < SLOTS);
  assign req_addr = req_r.address[AW-1:0];
  assign chk_addr = av_r[chk_idx_r] ? addr_q : '0;
  assign scan_more = (cnt_r < CW'(SLOTS));

  // set looks for a free slot, the others for an enabled address match
  assign match = chk_vld_r &&
                 ((req_r.mode == MODE_SET) ? !en_r[chk_idx_r]
                                           : (en_r[chk_idx_r] && chk_addr == req_addr));

  assign sts.mode     = req_r.mode;
  assign sts.sid_ok   = sid_ok;
  assign sts.match    = match;
  assign sts.scan_end = chk_vld_r && (chk_idx_r == SW'(SLOTS - 1));

  always_comb begin
    if (cmd.rd_match) begin
      rd_idx = chk_idx_r;
    end else if (cmd.rd_slot) begin
      rd_idx = sid_idx;
    end else begin
      rd_idx = cnt_r[SW-1:0];
    end
  end

  // memory read ports, registered
  always_ff @(posedge clk) begin
    addr_q <= addr_mem[rd_idx];
    attr_q <= attr_mem[rd_idx];
    hits_q <= hits_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[addr_wi] <= addr_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[attr_wi] <= attr_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (hits_we) begin
      hits_mem[hits_wi] <= hits_wd;
    end
  end

  assign hits_cur = hv_r[fnd_idx_r] ? hits_q : '0;

  always_comb begin
    en_nxt  = en_r;
    av_nxt  = av_r;
    hv_nxt  = hv_r;
    addr_we = 1'b0;
    attr_we = 1'b0;
    hits_we = 1'b0;
    addr_wi = chk_idx_r;
    attr_wi = chk_idx_r;
    hits_wi = chk_idx_r;
    addr_wd = '0;
    attr_wd = '{kind: req_r.bp_type, len: req_r.bp_length};
    hits_wd = '0;
    res_nxt = '0;

    if (cmd.retire_direct) begin
      if (req_r.mode == MODE_REM_SLOT) begin
        if (sid_ok && en_r[sid_idx]) begin
          en_nxt[sid_idx] = 1'b0;
          addr_we         = 1'b1;
          addr_wi         = sid_idx;
          res_nxt.ok      = 1'b1;
        end
      end else if (sid_ok) begin
        en_nxt[sid_idx] = (req_r.mode == MODE_ENABLE);
        res_nxt.ok      = 1'b1;
      end
    end

    if (cmd.retire_scan) begin
      res_nxt.ok       = 1'b1;
      res_nxt.slot_out = chk_wide[2:0];
      case (req_r.mode)
        MODE_SET: begin
          en_nxt[chk_idx_r] = 1'b1;
          av_nxt[chk_idx_r] = 1'b1;
          hv_nxt[chk_idx_r] = 1'b1;
          addr_we           = 1'b1;
          addr_wd           = req_addr;
          attr_we           = 1'b1;
          hits_we           = 1'b1;
        end
        MODE_REM_ADDR: begin
          en_nxt[chk_idx_r] = 1'b0;
          addr_we           = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (cmd.retire_fetch) begin
      res_nxt.ok = 1'b1;
      if (req_r.mode == MODE_HIT) begin
        hits_we            = 1'b1;
        hits_wi            = fnd_idx_r;
        hits_wd            = hits_cur + 32'd1;
        hv_nxt[fnd_idx_r]  = 1'b1;
        res_nxt.slot_out   = fnd_wide[2:0];
        res_nxt.entry_hits = hits_wd;
      end else begin
        res_nxt.entry_address = av_r[sid_idx] ? 32'(addr_q) : 32'd0;
        res_nxt.entry_type    = av_r[sid_idx] ? attr_q.kind : 2'd0;
        res_nxt.entry_length  = av_r[sid_idx] ? attr_q.len : 32'd1;
        res_nxt.entry_enabled = en_r[sid_idx];
        res_nxt.entry_hits    = hv_r[sid_idx] ? hits_q : 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= '0;
      av_r        <= '0;
      hv_r        <= '0;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      en_r        <= en_nxt;
      av_r        <= av_nxt;
      hv_r        <= hv_nxt;
      out_valid_r <= cmd.retire_direct | cmd.retire_scan |
                     cmd.retire_fetch | cmd.retire_fail;
      if (cmd.load_req) begin
        cnt_r     <= '0;
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_run && scan_more) begin
        cnt_r     <= cnt_r + CW'(1);
        chk_vld_r <= 1'b1;
      end else begin
        chk_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_word;
    end
    if (cmd.scan_run) begin
      chk_idx_r <= cnt_r[SW-1:0];
    end
    if (cmd.rd_match) begin
      fnd_idx_r <= chk_idx_r;
    end
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

endmodule

@@ rtl/breakpoint_slot_table.sv @@
// Top level of the breakpoint slot table.
// Depends on bst_pkg, bst_ctrl and bst_dp.
//
//   channel   ports                   handshake
//   request   in_word                 taken when start high and busy low
//   result    out_word                out_valid high for one cycle, no stall
//
// A request occupies the block from acceptance until its result strobe.
// Slot-number requests and out-of-range reads retire from dispatch, read after
// a fetch of the slot; lookups and set walk the slots one per cycle through
// the address memory read port, hit with a fetch of the match's hit count.
// A new request may be accepted in the cycle the previous result shows.
// Reset is synchronous; all slots read as empty right after it, no sweep.
`timescale 1ns / 1ps

module breakpoint_slot_table
  import bst_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bst_in_t  in_word,
  output logic     out_valid,
  output bst_out_t out_word
);

  bst_cmd_t cmd;
  bst_sts_t sts;

  bst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bst_dp #(
    .SLOTS     (SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ rtl/bst_checker.sv @@
// Port-level checks for the breakpoint slot table, bound to the top level.
// Depends on bst_pkg.
`timescale 1ns / 1ps

module bst_checker
  import bst_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input bst_out_t out_word
);

  // an accepted word holds the block until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a word in flight");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes for one word");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.ok |->
      out_word.slot_out == 3'd0 && out_word.entry_hits == 32'd0 &&
      out_word.entry_enabled == 1'b0)
    else $error("failed result carries data");

endmodule

bind breakpoint_slot_table bst_checker u_bst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
